// ===== src/upd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared payload types, state record, phase and status codes, and widths.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int LENGTH_BITS = 16;
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;
    localparam int MAX_RESULTS = 3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_ESCAPE = 2'd1;
    localparam logic [1:0] ST_NO_PERCENT = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CASE_MASK  = 8'hdf;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } upd_in_t;

    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   last_of_run;
        logic                   string_done;
        logic [1:0]             status;
        logic [LENGTH_BITS-1:0] decoded_length;
    } upd_out_t;

    typedef struct packed {
        logic [1:0]             escape_phase;
        logic [7:0]             held_digit;
        logic                   percent_seen;
        logic                   bad_escape_seen;
        logic [LENGTH_BITS-1:0] byte_count;
    } upd_state_t;

    localparam upd_state_t STATE_RESET = '{
        escape_phase:    PH_IDLE,
        held_digit:      8'h00,
        percent_seen:    1'b0,
        bad_escape_seen: 1'b0,
        byte_count:      '0
    };

endpackage

// ===== src/upd_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder step logic
// Turns one input byte and the current decoder state into up to three
// result records and the state that follows.
// ----------------------------------------------------------------------------
module upd_step
    import upd_pkg::*;
(
    input  upd_in_t                     item,
    input  upd_state_t                  state_cur,
    output upd_state_t                  state_next,
    output logic [1:0]                  res_count,
    output upd_out_t [MAX_RESULTS-1:0]  res
);

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h41) begin
            v = (c & CASE_MASK) - 8'h41 + 8'd10;
        end else begin
            v = c - 8'h30;
        end
        return v[3:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] c,
                                                       input logic [1:0] k);
        logic [LENGTH_BITS+1:0] sum;
        sum = {2'b00, c} + (LENGTH_BITS+2)'(k);
        return (sum > (LENGTH_BITS+2)'(LENGTH_MAX)) ? LENGTH_MAX : sum[LENGTH_BITS-1:0];
    endfunction

    logic [7:0] b;
    logic       fin;
    logic       b_hex;
    logic       in_pct;
    logic       in_digit;
    logic       plain_act;
    logic       plain_pct;
    logic [1:0] phase_after;
    logic [7:0] held_after;
    logic       pct_after;
    logic       bad_after;
    logic [4:0] slot_en;
    logic [7:0] slot_byte [5];
    logic [7:0] list [MAX_RESULTS];
    logic [1:0] n;
    logic [1:0] status_code;

    always_comb begin
        b        = item.in_byte;
        fin      = item.end_of_input;
        b_hex    = is_hex(b);
        in_pct   = (state_cur.escape_phase == PH_PCT);
        in_digit = (state_cur.escape_phase == PH_DIGIT);

        plain_act = !(in_pct && b_hex) && !(in_digit && b_hex);
        plain_pct = plain_act && (b == CH_PERCENT);

        if (in_pct && b_hex) begin
            phase_after = PH_DIGIT;
        end else if (plain_pct) begin
            phase_after = PH_PCT;
        end else begin
            phase_after = PH_IDLE;
        end
        held_after = (in_pct && b_hex) ? b : state_cur.held_digit;
        pct_after  = state_cur.percent_seen | plain_pct;

        slot_en[0]   = (in_pct || in_digit) && !b_hex;
        slot_byte[0] = CH_PERCENT;
        slot_en[1]   = in_digit;
        slot_byte[1] = b_hex ? {hex_val(state_cur.held_digit), hex_val(b)}
                             : state_cur.held_digit;
        slot_en[2]   = plain_act && (b != CH_PERCENT);
        slot_byte[2] = (state_cur.percent_seen && b == CH_PLUS) ? CH_SPACE : b;
        slot_en[3]   = fin && (phase_after != PH_IDLE);
        slot_byte[3] = CH_PERCENT;
        slot_en[4]   = fin && (phase_after == PH_DIGIT);
        slot_byte[4] = held_after;

        bad_after = state_cur.bad_escape_seen | slot_en[0] | slot_en[3];

        n = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            list[i] = 8'h00;
        end
        for (int j = 0; j < 5; j++) begin
            if (slot_en[j] && n != 2'd3) begin
                list[n] = slot_byte[j];
                n = n + 2'd1;
            end
        end

        if (!pct_after) begin
            status_code = ST_NO_PERCENT;
        end else if (bad_after) begin
            status_code = ST_BAD_ESCAPE;
        end else begin
            status_code = ST_OK;
        end

        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k].out_byte       = list[k];
            res[k].last_of_run    = (2'(k + 1) == n);
            res[k].string_done    = (2'(k + 1) == n) && fin;
            res[k].status         = ((2'(k + 1) == n) && fin) ? status_code : ST_OK;
            res[k].decoded_length = sat_add(state_cur.byte_count, 2'(k + 1));
        end
        res_count = n;

        if (fin) begin
            state_next = STATE_RESET;
        end else begin
            state_next.escape_phase    = phase_after;
            state_next.held_digit      = held_after;
            state_next.percent_seen    = pct_after;
            state_next.bad_escape_seen = bad_after;
            state_next.byte_count      = sat_add(state_cur.byte_count, n);
        end
    end

endmodule

// ===== src/url_percent_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder for URL-encoded strings, one encoded byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one encoded byte per cycle while m_ready is high and gives
// each of its decoded bytes as a result transfer, with the running length
// and, on the final result of a string, the status. An accepted byte is
// registered, then decoded, and its results land in a three-entry result
// register once it has room. A byte with at most one result lets the next
// byte in every cycle while m_ready is high; one with two or three results
// holds the input until its last result goes out; results leave one per
// cycle while m_ready is high. A percent sign, or the first hex digit of an
// escape, yields no result of its own unless it ends the string.
module url_percent_decode
    import upd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  upd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output upd_out_t m_data
);

    upd_in_t                    in_reg;
    logic                       in_valid_reg;
    logic                       in_valid_next;
    upd_state_t                 state_reg;
    upd_state_t                 state_next;
    upd_out_t                   res_reg [MAX_RESULTS];
    logic [1:0]                 res_cnt_reg;
    logic [1:0]                 res_cnt_next;
    logic [1:0]                 step_count;
    upd_out_t [MAX_RESULTS-1:0] step_res;
    logic                       load_ok;
    logic                       consume;
    logic                       m_xfer;

    upd_step u_step (
        .item       (in_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .res_count  (step_count),
        .res        (step_res)
    );

    assign m_valid = (res_cnt_reg != 2'd0);
    assign m_data  = res_reg[0];
    assign m_xfer  = m_valid && m_ready;
    assign load_ok = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && m_ready);
    assign consume = in_valid_reg && load_ok;
    assign s_ready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = s_ready ? s_valid : in_valid_reg;
        if (consume) begin
            res_cnt_next = step_count;
        end else if (m_xfer) begin
            res_cnt_next = res_cnt_reg - 2'd1;
        end else begin
            res_cnt_next = res_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            res_cnt_reg  <= 2'd0;
            state_reg    <= STATE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            res_cnt_reg  <= res_cnt_next;
            if (consume) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (consume) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                res_reg[k] <= step_res[k];
            end
        end else if (m_xfer) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                res_reg[k] <= res_reg[k+1];
            end
        end
    end

endmodule

// ===== tb/url_percent_decode_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder testbench
// Drives encoded strings into the decoder with random gaps on both channels.
// A scoreboard class mirrors the decoding rules and checks every result
// transfer field by field. The strings cover pass-through before the first
// percent sign, good and broken escapes, and escapes left open at the end of
// a string, followed by random strings.
// ----------------------------------------------------------------------------
module url_percent_decode_tb;
    import upd_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    class decode_scoreboard;
        upd_out_t expected_q[$];
        int errors;
        logic [1:0] phase;
        logic [7:0] held;
        bit pct_seen;
        bit bad_seen;
        logic [LENGTH_BITS-1:0] count;
        logic [7:0] run_bytes[$];
        logic [LENGTH_BITS-1:0] run_lens[$];

        function new();
            errors = 0;
            clear_string();
        endfunction

        function void clear_string();
            phase = PH_IDLE;
            held = 8'h00;
            pct_seen = 1'b0;
            bad_seen = 1'b0;
            count = '0;
        endfunction

        static function bit is_hex_digit(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                   (c >= "A" && c <= "F");
        endfunction

        static function logic [3:0] nibble(logic [7:0] c);
            logic [7:0] v;
            if (c >= "A") begin
                v = (c & CASE_MASK) - "A" + 8'd10;
            end else begin
                v = c - "0";
            end
            return v[3:0];
        endfunction

        function void put_byte(logic [7:0] b);
            if (run_bytes.size() < MAX_RESULTS) begin
                if (count != LENGTH_MAX) count++;
                run_bytes.push_back(b);
                run_lens.push_back(count);
            end
        endfunction

        function void take_plain(logic [7:0] b);
            if (b == CH_PERCENT) begin
                pct_seen = 1'b1;
                phase = PH_PCT;
            end else if (pct_seen && b == CH_PLUS) begin
                put_byte(CH_SPACE);
            end else begin
                put_byte(b);
            end
        endfunction

        function void note_input(upd_in_t item);
            logic [7:0] b;
            bit is_final;
            logic [1:0] st;
            upd_out_t r;
            b = item.in_byte;
            is_final = item.end_of_input;
            run_bytes.delete();
            run_lens.delete();
            case (phase)
                PH_PCT: begin
                    if (is_hex_digit(b)) begin
                        held = b;
                        phase = PH_DIGIT;
                    end else begin
                        bad_seen = 1'b1;
                        put_byte(CH_PERCENT);
                        phase = PH_IDLE;
                        take_plain(b);
                    end
                end
                PH_DIGIT: begin
                    phase = PH_IDLE;
                    if (is_hex_digit(b)) begin
                        put_byte({nibble(held), nibble(b)});
                    end else begin
                        bad_seen = 1'b1;
                        put_byte(CH_PERCENT);
                        put_byte(held);
                        take_plain(b);
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    take_plain(b);
                end
            endcase
            st = ST_OK;
            if (is_final) begin
                if (phase == PH_PCT) begin
                    bad_seen = 1'b1;
                    put_byte(CH_PERCENT);
                end else if (phase == PH_DIGIT) begin
                    bad_seen = 1'b1;
                    put_byte(CH_PERCENT);
                    put_byte(held);
                end
                if (!pct_seen) st = ST_NO_PERCENT;
                else if (bad_seen) st = ST_BAD_ESCAPE;
                else st = ST_OK;
            end
            foreach (run_bytes[k]) begin
                r.out_byte = run_bytes[k];
                r.last_of_run = (k == run_bytes.size() - 1);
                r.string_done = r.last_of_run && is_final;
                r.status = r.string_done ? st : ST_OK;
                r.decoded_length = run_lens[k];
                expected_q.push_back(r);
            end
            if (is_final) clear_string();
        endfunction

        function void check_result(upd_out_t got);
            upd_out_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer: out_byte %0h", got.out_byte);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                       got.last_of_run);
                errors++;
            end
            if (got.string_done !== want.string_done) begin
                $error("string_done: expected %0d, got %0d", want.string_done,
                       got.string_done);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.decoded_length !== want.decoded_length) begin
                $error("decoded_length: expected %0d, got %0d", want.decoded_length,
                       got.decoded_length);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    upd_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    upd_out_t m_data;

    decode_scoreboard sb = new();
    bit no_idle = 1'b0;
    int random_items = 0;

    url_percent_decode u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] random_hex();
        int n;
        n = $urandom_range(0, 21);
        if (n < 10) return 8'("0" + n);
        if (n < 16) return 8'("a" + n - 10);
        return 8'("A" + n - 16);
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (decode_scoreboard::is_hex_digit(c));
        return c;
    endfunction

    function automatic logic [7:0] random_non_percent();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_PERCENT);
        return c;
    endfunction

    task automatic push_encoded_byte(logic [7:0] b, logic is_final);
        int gap;
        upd_in_t item;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.in_byte = b;
        item.end_of_input = is_final;
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(item);
    endtask

    task automatic send_bytes(byte_q_t bytes);
        foreach (bytes[i]) begin
            push_encoded_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    task automatic send_text(string txt);
        byte_q_t bytes;
        for (int i = 0; i < txt.len(); i++) bytes.push_back(txt[i]);
        send_bytes(bytes);
    endtask

    task automatic send_random_string();
        byte_q_t text;
        int len;
        int kind;
        bit plain_only;
        len = $urandom_range(1, 12);
        plain_only = ($urandom_range(0, 4) == 0);
        no_idle = ($urandom_range(0, 7) == 0);
        while (text.size() < len) begin
            kind = plain_only ? 0 : $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    text.push_back(plain_only ? random_non_percent()
                                              : 8'($urandom_range(0, 255)));
                end
                4, 5: begin
                    text.push_back(CH_PERCENT);
                    text.push_back(random_hex());
                    text.push_back(random_hex());
                end
                6: text.push_back(CH_PLUS);
                7: begin
                    text.push_back(CH_PERCENT);
                    if ($urandom_range(0, 1)) text.push_back(random_hex());
                    text.push_back(random_non_hex());
                end
                8: text.push_back(CH_PERCENT);
                default: text.push_back(random_hex());
            endcase
        end
        random_items += text.size();
        send_bytes(text);
    endtask

    initial begin
        int m_stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            m_stall = no_idle ? 0 : $urandom_range(0, 4);
            if (m_stall > 0) begin
                m_ready <= 1'b0;
                repeat (m_stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text("a+b");
        send_text("%41+%7e");
        send_text("%2B%2b+");
        send_text("%");
        send_text("%4");
        send_text("%4g");
        send_text("%%41");
        send_text("x%zq");
        send_bytes({8'h00, CH_PERCENT, 8'h46, 8'h66, 8'hff});
        send_text("%aF%Fa%09");

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);

        while (random_items < 205) send_random_string();
        no_idle = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule
